@@ src/wsps_pkg.sv @@
// Shared types and constants for the pixel serializer.
// Holds operation codes, phase codes, register indexes and result bit places.
// No dependencies.
`default_nettype none

package wsps_pkg;

  // Operation carried in tuser of each input item
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_SHOW = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Block phase, one-hot
  typedef enum logic [3:0] {
    PH_CLEAR = 4'b0001,
    PH_IDLE  = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_SEND  = 4'b1000
  } phase_t;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_ORDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP   = 3'd6;

  // Register widths and reset values
  localparam int LED_COUNT_W = 9;
  localparam int TICK_W      = 16;
  localparam int GAP_W       = 20;

  localparam logic [7:0]             BRIGHTNESS_RST  = 8'd50;
  localparam logic [7:0]             PIXEL_ORDER_RST = 8'd82;
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST   = 9'd256;
  localparam logic [TICK_W-1:0]      ZERO_HIGH_RST   = 16'd32;
  localparam logic [TICK_W-1:0]      ONE_HIGH_RST    = 16'd64;
  localparam logic [TICK_W-1:0]      BIT_PERIOD_RST  = 16'd100;
  localparam logic [GAP_W-1:0]       LATCH_GAP_RST   = 20'd24000;
  localparam logic [GAP_W-1:0]       GAP_MAX         = 20'hFFFFF;

  // Result bit places in m_tdata
  localparam int RES_PIN     = 0;
  localparam int RES_BUSY    = 1;
  localparam int RES_REFUSED = 2;

endpackage

`default_nettype wire

@@ src/ws2812_pixel_serializer_top.sv @@
// Top level of the one-wire LED pixel serializer.
// Holds the pixel byte store, the bit timing logic and the result buffer.
// Depends on wsps_pkg.
`default_nettype none

// One item is taken per clock cycle while s_tready is high, and its result
// is registered; a two-entry result buffer lets input items keep flowing
// while one result waits to be taken. After reset the pixel store is cleared
// one row of four bytes a cycle, with s_tready low; configuration writes
// are taken during that time. The store is four byte lanes, so a set-pixel
// item writes all its bytes in the same cycle, and while sending, the byte
// after the current one is read ahead from the store.
module ws2812_pixel_serializer_top
  import wsps_pkg::*;
#(
  parameter int MAX_LEDS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,   // pixel_index[7:0], color[39:8]
  input  logic [1:0]            s_tuser,   // operation[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // data_pin[0], busy_res[1], refused[2], zero[7:3]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int ADDR_W = ROW_W + 2;
  localparam int PTR_W  = ADDR_W + 1;
  localparam int CNT_W  = $clog2(MAX_LEDS + 1);
  localparam int EW     = (CNT_W > LED_COUNT_W) ? CNT_W : LED_COUNT_W;
  localparam int BW     = (ADDR_W > 10) ? ADDR_W : 10;

  // Configuration registers
  logic [7:0]             brightness;
  logic [7:0]             pixel_order;
  logic [LED_COUNT_W-1:0] led_count;
  logic [TICK_W-1:0]      zero_high_ticks;
  logic [TICK_W-1:0]      one_high_ticks;
  logic [TICK_W-1:0]      bit_period_ticks;
  logic [GAP_W-1:0]       latch_gap_ticks;

  // Serializer state
  phase_t             phase, phase_next;
  logic [PTR_W-1:0]   byte_pointer, byte_pointer_next;
  logic [2:0]         bit_position, bit_position_next;
  logic [TICK_W-1:0]  tick_in_bit, tick_in_bit_next;
  logic [GAP_W-1:0]   gap_counter, gap_counter_next;
  logic [7:0]         cur_byte, cur_byte_next;
  logic [7:0]         byte0;
  logic [ROW_W-1:0]   clr_row;

  // Store lanes
  logic [3:0]         wr_en;
  logic [ROW_W-1:0]   wr_row [4];
  logic [7:0]         wr_data [4];
  logic [7:0]         rd_q [4];
  logic [1:0]         rd_lane;
  logic [PTR_W-1:0]   rd_addr_full;
  logic [ADDR_W-1:0]  rd_addr;

  // Result buffer
  logic               out_valid;
  logic [7:0]         out_data;
  logic               skid_valid;
  logic [7:0]         skid_data;

  // Item decode
  logic               acc;
  op_t                op;
  logic [7:0]         pixel_index;
  logic [31:0]        color;
  logic               busy;
  logic               refused;
  logic               do_set;
  logic               data_pin;
  logic [7:0]         result;

  // Derived values
  logic [EW-1:0]      led_wide;
  logic [CNT_W-1:0]   eff_leds;
  logic               bpp4;
  logic [PTR_W-1:0]   leds_ext;
  logic [PTR_W-1:0]   frame_bytes;
  logic [TICK_W-1:0]  period;
  logic               idx_ok;
  logic [BW-1:0]      idx_ext;
  logic [BW-1:0]      base;
  logic [BW-1:0]      addr_full [4];
  logic [7:0]         scaled [4];
  logic [1:0]         offs [4];
  logic [3:0]         col_en;
  logic [TICK_W-1:0]  tick_inc;
  logic               bit_end;
  logic [PTR_W-1:0]   ptr_step;
  logic [GAP_W-1:0]   gap_inc;
  logic [TICK_W-1:0]  high_ticks;

  function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [7:0] br);
    logic [15:0] prod;
    prod = 16'(v) * 16'(br);
    return (br == 8'd0) ? v : prod[15:8];
  endfunction

  assign acc         = s_tvalid && s_tready;
  assign op          = op_t'(s_tuser);
  assign pixel_index = s_tdata[7:0];
  assign color       = s_tdata[39:8];
  assign busy        = (phase == PH_WAIT) || (phase == PH_SEND);

  // Frame geometry from the live registers
  assign led_wide    = EW'(led_count);
  assign eff_leds    = (led_wide > EW'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : CNT_W'(led_count);
  assign bpp4        = pixel_order[7:6] != pixel_order[5:4];
  assign leds_ext    = PTR_W'(eff_leds);
  assign frame_bytes = bpp4 ? (leds_ext << 2) : (leds_ext + (leds_ext << 1));
  assign period      = (bit_period_ticks == '0) ? TICK_W'(1) : bit_period_ticks;
  assign idx_ok      = EW'(pixel_index) < EW'(eff_leds);

  // Byte addresses and scaled colour bytes, white first, blue last
  assign idx_ext = BW'(pixel_index);
  assign base    = bpp4 ? (idx_ext << 2) : (idx_ext + (idx_ext << 1));
  assign col_en  = {3'b111, bpp4};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      offs[c]      = pixel_order[2*(3-c) +: 2];
      addr_full[c] = base + BW'(offs[c]);
      scaled[c]    = scale_byte(color[8*(3-c) +: 8], brightness);
    end
  end

  // Lane write selection: later colours win on a shared lane
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      wr_en[l]   = 1'b0;
      wr_row[l]  = clr_row;
      wr_data[l] = 8'd0;
      if (phase == PH_CLEAR) begin
        wr_en[l] = 1'b1;
      end else begin
        for (int c = 0; c < 4; c++) begin
          if (do_set && col_en[c] && (addr_full[c][1:0] == 2'(l))) begin
            wr_en[l]   = 1'b1;
            wr_row[l]  = addr_full[c][ADDR_W-1:2];
            wr_data[l] = scaled[c];
          end
        end
      end
    end
  end

  // Read ahead the byte after the current one
  assign rd_addr_full = byte_pointer + PTR_W'(1);
  assign rd_addr      = rd_addr_full[ADDR_W-1:0];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0] mem [MAX_LEDS];
    always_ff @(posedge clk) begin
      if (wr_en[l]) begin
        mem[wr_row[l]] <= wr_data[l];
      end
      rd_q[l] <= mem[rd_addr[ADDR_W-1:2]];
    end
  end

  always_ff @(posedge clk) begin
    rd_lane <= rd_addr[1:0];
  end

  // Per-item state update
  assign tick_inc = tick_in_bit + TICK_W'(1);
  assign bit_end  = (tick_inc >= period) || (tick_inc == '0);
  assign ptr_step = (bit_position == 3'd0) ? (byte_pointer + PTR_W'(1)) : byte_pointer;
  assign gap_inc  = (gap_counter < GAP_MAX) ? (gap_counter + GAP_W'(1)) : gap_counter;

  always_comb begin
    phase_next        = phase;
    byte_pointer_next = byte_pointer;
    bit_position_next = bit_position;
    tick_in_bit_next  = tick_in_bit;
    gap_counter_next  = gap_counter;
    cur_byte_next     = cur_byte;
    refused           = 1'b0;
    do_set            = 1'b0;
    if (phase == PH_CLEAR) begin
      if (clr_row == ROW_W'(MAX_LEDS - 1)) begin
        phase_next = PH_IDLE;
      end
    end else if (acc) begin
      unique case (op)
        OP_SET: begin
          if (busy) begin
            refused = 1'b1;
          end else begin
            do_set = idx_ok;
          end
        end
        OP_SHOW: begin
          if (busy) begin
            refused = 1'b1;
          end else if (eff_leds != '0) begin
            if (gap_counter >= latch_gap_ticks) begin
              phase_next        = PH_SEND;
              byte_pointer_next = '0;
              bit_position_next = 3'd7;
              tick_in_bit_next  = '0;
              cur_byte_next     = byte0;
            end else begin
              phase_next = PH_WAIT;
            end
          end
        end
        OP_TICK: begin
          if (phase == PH_SEND) begin
            tick_in_bit_next = tick_inc;
            if (bit_end) begin
              tick_in_bit_next  = '0;
              byte_pointer_next = ptr_step;
              if (bit_position != 3'd0) begin
                bit_position_next = bit_position - 3'd1;
              end else begin
                bit_position_next = 3'd7;
                cur_byte_next     = rd_q[rd_lane];
              end
              if (ptr_step >= frame_bytes) begin
                phase_next        = PH_IDLE;
                byte_pointer_next = '0;
                bit_position_next = 3'd7;
                gap_counter_next  = '0;
              end
            end
          end else begin
            gap_counter_next = gap_inc;
            if ((phase == PH_WAIT) && (gap_inc >= latch_gap_ticks)) begin
              phase_next        = PH_SEND;
              byte_pointer_next = '0;
              bit_position_next = 3'd7;
              tick_in_bit_next  = '0;
              cur_byte_next     = byte0;
            end
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Line level after the item
  assign high_ticks = cur_byte_next[bit_position_next] ? one_high_ticks : zero_high_ticks;
  assign data_pin   = (phase_next == PH_SEND) && (tick_in_bit_next < high_ticks);
  assign result     = {5'd0, refused, (phase_next == PH_WAIT) || (phase_next == PH_SEND),
                       data_pin};

  // Hold state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CLEAR;
      clr_row      <= '0;
      byte_pointer <= '0;
      bit_position <= 3'd7;
      tick_in_bit  <= '0;
      gap_counter  <= GAP_MAX;
      byte0        <= 8'd0;
    end else begin
      phase        <= phase_next;
      byte_pointer <= byte_pointer_next;
      bit_position <= bit_position_next;
      tick_in_bit  <= tick_in_bit_next;
      gap_counter  <= gap_counter_next;
      if (phase == PH_CLEAR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      // Shadow of the first byte, needed in the cycle a frame starts
      if (wr_en[0] && (wr_row[0] == '0)) begin
        byte0 <= wr_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness       <= BRIGHTNESS_RST;
      pixel_order      <= PIXEL_ORDER_RST;
      led_count        <= LED_COUNT_RST;
      zero_high_ticks  <= ZERO_HIGH_RST;
      one_high_ticks   <= ONE_HIGH_RST;
      bit_period_ticks <= BIT_PERIOD_RST;
      latch_gap_ticks  <= LATCH_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHTNESS:  brightness       <= cfg_data[7:0];
        REG_PIXEL_ORDER: pixel_order      <= cfg_data[7:0];
        REG_LED_COUNT:   led_count        <= cfg_data[LED_COUNT_W-1:0];
        REG_ZERO_HIGH:   zero_high_ticks  <= cfg_data[TICK_W-1:0];
        REG_ONE_HIGH:    one_high_ticks   <= cfg_data[TICK_W-1:0];
        REG_BIT_PERIOD:  bit_period_ticks <= cfg_data[TICK_W-1:0];
        REG_LATCH_GAP:   latch_gap_ticks  <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Two-entry result buffer: output register plus skid stage
  assign s_tready = (phase != PH_CLEAR) && !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= acc;
      end else begin
        out_valid  <= acc;
      end
    end else if (acc) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (acc) begin
          skid_data <= result;
        end
      end else if (acc) begin
        out_data <= result;
      end
    end else if (acc) begin
      if (out_valid) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/wsps_checker.sv @@
// Port-level checks for the pixel serializer, with the bind to the top level.
// Sees only the top level's ports. Depends on wsps_pkg.
`default_nettype none

module wsps_checker
  import wsps_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // Store clear blocks input items right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !s_tready)
    else $error("input taken during store clear");

  // A refused item leaves the block busy
  a_refused_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[RES_REFUSED] |-> m_tdata[RES_BUSY])
    else $error("refused result while not busy");

  // The line is only driven high during a frame
  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[RES_PIN] |-> m_tdata[RES_BUSY])
    else $error("line high while not busy");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind ws2812_pixel_serializer_top wsps_checker u_wsps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
